### hw/rtl/trv_pkg.sv
// ----------------------------------------------------------------------------
// Track read-back verifier package
// Shared types, register indexes, verdict codes and the sectors-per-track
// table used by the verifier modules.
// ----------------------------------------------------------------------------
package trv_pkg;

    localparam int COUNT_W   = 14;
    localparam int BYTE_W    = 8;
    localparam int HTRACK_W  = 7;
    localparam int SECT_W    = 5;
    localparam int TOL_W     = 9;
    localparam int VERDICT_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_HALFTRACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_TOL = 2'd1;

    localparam logic [VERDICT_W-1:0] VERDICT_OK    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_WEAK  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_RETRY = 2'd2;

    typedef struct packed {
        logic mismatch;
        logic bad_nibble;
        logic last;
    } pair_flags_t;

    function automatic logic [SECT_W-1:0] sectors_of_track(
        input logic [HTRACK_W-2:0] track
    );
        logic [SECT_W-1:0] sect;
        case (track) inside
            [6'd1:6'd17]:  sect = 5'd21;
            [6'd18:6'd24]: sect = 5'd19;
            [6'd25:6'd30]: sect = 5'd18;
            [6'd31:6'd42]: sect = 5'd17;
            default:       sect = 5'd0;
        endcase
        return sect;
    endfunction

    function automatic logic nibble_is_bad(input logic [BYTE_W-1:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = b[7:4];
        lo = b[3:0];
        return (hi == 4'h0) || (hi == 4'hF) || (lo == 4'h0) || (lo == 4'hF);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

### hw/rtl/track_readback_verifier_unit.sv
// ----------------------------------------------------------------------------
// Track read-back verifier
// Compares written and read-back track bytes, counts differing pairs and
// bad-GCR read bytes, and reports a verdict at the end of each track.
//
//   Channel   Direction  Contents
//   s_*       in         written byte and read byte per transfer, tlast ends
//   m_*       out        one verdict transfer per track
//   cfg_*     in         halftrack number and extra tolerance writes
//
// A byte pair can be accepted in every cycle unless a last pair is held by a
// stalled verdict. The input register holds each pair until the tally stage
// takes it into the counters, and a last pair loads the verdict register at that same edge.
// The input register and the result register decouple the two sides, so a
// stalled verdict blocks only a following last pair.
// Reset clears the counters and loads halftrack 2 with zero extra tolerance.
// ----------------------------------------------------------------------------
module track_readback_verifier_unit #(
    parameter int TRACK_BYTES = 8192
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // read_byte, written_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [trv_pkg::OUT_W-1:0]      m_tdata,  // mismatch_total, bad_gcr_count,
                                                     // verdict, passed
    input  logic                           cfg_we,
    input  logic [trv_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [trv_pkg::BYTE_W-1:0]     cfg_wdata
);
    import trv_pkg::*;

    logic [HTRACK_W-1:0] halftrack_reg;
    logic [BYTE_W-1:0]   extra_tol_reg;
    logic                pair_valid;
    pair_flags_t         pair_flags;
    logic                pair_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halftrack_reg <= HTRACK_W'(2);
            extra_tol_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HALFTRACK: halftrack_reg <= cfg_wdata[HTRACK_W-1:0];
                REG_EXTRA_TOL: extra_tol_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    trv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .pair_valid (pair_valid),
        .pair_flags (pair_flags),
        .pair_take  (pair_take)
    );

    trv_tally #(
        .TRACK_BYTES (TRACK_BYTES)
    ) u_tally (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pair_valid       (pair_valid),
        .pair_flags       (pair_flags),
        .pair_take        (pair_take),
        .halftrack_number (halftrack_reg),
        .extra_tolerance  (extra_tol_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[29:28] == VERDICT_OK) |-> (m_tdata[27:14] == '0))
        else $error("bad_gcr_count not zero on an OK verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30] == (m_tdata[29:28] != VERDICT_RETRY)))
        else $error("passed flag disagrees with verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[29:28] == VERDICT_WEAK) |-> (m_tdata[13:0] <= m_tdata[27:14]))
        else $error("weak verdict with more differences than bad-GCR bytes");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && pair_valid && pair_flags.last |-> !pair_take)
        else $error("last pair taken while the verdict register is full");
`endif

endmodule

### hw/rtl/trv_front.sv
// ----------------------------------------------------------------------------
// Track read-back verifier input stage
// Registers each accepted byte pair as a compare flag, a bad-nibble flag and
// the last marker, and holds it until the tally stage takes it.
// ----------------------------------------------------------------------------
module trv_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,
    input  logic                      s_tlast,
    output logic                      pair_valid,
    output trv_pkg::pair_flags_t      pair_flags,
    input  logic                      pair_take
);
    import trv_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    pair_flags_t flags_reg;

    assign s_tready   = !valid_reg || pair_take;
    assign pair_valid = valid_reg;
    assign pair_flags = flags_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            flags_reg.mismatch   <= (s_tdata[7:0] != s_tdata[15:8]);
            flags_reg.bad_nibble <= nibble_is_bad(s_tdata[15:8]);
            flags_reg.last       <= s_tlast;
        end
    end

endmodule

### hw/rtl/trv_tally.sv
// ----------------------------------------------------------------------------
// Track read-back verifier tally stage
// Keeps the per-track mismatch, bad-nibble and position counters, and on the
// last pair loads the verdict into the result register.
// ----------------------------------------------------------------------------
module trv_tally #(
    parameter int TRACK_BYTES = 8192
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             pair_valid,
    input  trv_pkg::pair_flags_t             pair_flags,
    output logic                             pair_take,
    input  logic [trv_pkg::HTRACK_W-1:0]     halftrack_number,
    input  logic [trv_pkg::BYTE_W-1:0]       extra_tolerance,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [trv_pkg::OUT_W-1:0]        m_tdata
);
    import trv_pkg::*;

    localparam int POS_W = $clog2(TRACK_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TRACK_BYTES);

    logic [COUNT_W-1:0]   mis_reg;
    logic [COUNT_W-1:0]   mis_next;
    logic [COUNT_W-1:0]   bad_reg;
    logic [COUNT_W-1:0]   bad_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic                 mvalid_reg;
    logic                 mvalid_next;
    logic [COUNT_W-1:0]   diff_out_reg;
    logic [COUNT_W-1:0]   bad_out_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic                 passed_reg;

    logic                 in_range;
    logic [COUNT_W-1:0]   mis_upd;
    logic [COUNT_W-1:0]   bad_upd;
    logic [TOL_W-1:0]     tolerance;
    logic [VERDICT_W-1:0] verdict_calc;
    logic                 emit;

    assign pair_take = pair_valid && (!pair_flags.last || !mvalid_reg || m_tready);
    assign emit      = pair_take && pair_flags.last;
    assign in_range  = pos_reg < POS_LIMIT;
    assign mis_upd   = (in_range && pair_flags.mismatch)   ? sat_inc(mis_reg) : mis_reg;
    assign bad_upd   = (in_range && pair_flags.bad_nibble) ? sat_inc(bad_reg) : bad_reg;
    assign tolerance = TOL_W'(sectors_of_track(halftrack_number[HTRACK_W-1:1]))
                     + TOL_W'(extra_tolerance);

    always_comb begin
        if (mis_upd <= COUNT_W'(tolerance)) begin
            verdict_calc = VERDICT_OK;
        end else if (mis_upd <= bad_upd) begin
            verdict_calc = VERDICT_WEAK;
        end else begin
            verdict_calc = VERDICT_RETRY;
        end
    end

    always_comb begin
        mis_next    = mis_reg;
        bad_next    = bad_reg;
        pos_next    = pos_reg;
        mvalid_next = mvalid_reg;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        if (pair_take) begin
            if (pair_flags.last) begin
                mis_next    = '0;
                bad_next    = '0;
                pos_next    = '0;
                mvalid_next = 1'b1;
            end else begin
                mis_next = mis_upd;
                bad_next = bad_upd;
                pos_next = in_range ? pos_reg + 1'b1 : pos_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mis_reg    <= '0;
            bad_reg    <= '0;
            pos_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            mis_reg    <= mis_next;
            bad_reg    <= bad_next;
            pos_reg    <= pos_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            diff_out_reg <= mis_upd;
            bad_out_reg  <= (verdict_calc == VERDICT_OK) ? '0 : bad_upd;
            verdict_reg  <= verdict_calc;
            passed_reg   <= (verdict_calc != VERDICT_RETRY);
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {1'b0, passed_reg, verdict_reg, bad_out_reg, diff_out_reg};

endmodule
